>>> rtl/core/hcm37_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm37_pkg: shared types, constants and helpers of the mod-37 Hill encryptor
// Symbol mapping, key entry reduction and the constant-divisor modulo.
// ----------------------------------------------------------------------------
package hcm37_pkg;

  localparam int SYM_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int KEY_REGS   = 4;
  localparam int KEY_ROW_W  = KEY_REGS * SYM_W;
  localparam int CFG_ADDR_W = 3;
  localparam int BSIZE_W    = 3;
  localparam int SUM_W      = 14;

  localparam logic [SYM_W-1:0] ALPHA      = 6'd37;
  localparam logic [SYM_W-1:0] PAD_SYMBOL = 6'd36;
  localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd26;

  // Reciprocal of 37 scaled by 2^20; exact for every sum below 2^18.
  localparam int               RECIP_SHIFT = 20;
  localparam logic [14:0]      RECIP       = 15'd28340;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 3'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BLOCK_SIZE    = 3'd0,
    REG_KEY_ROW_ZERO  = 3'd1,
    REG_KEY_ROW_ONE   = 3'd2,
    REG_KEY_ROW_TWO   = 3'd3,
    REG_KEY_ROW_THREE = 3'd4
  } cfg_reg_t;

  typedef logic [KEY_REGS-1:0][KEY_ROW_W-1:0] key_rows_t;

  function automatic logic [SYM_W-1:0] to_symbol(input logic [CHAR_W-1:0] ch);
    logic [SYM_W-1:0] sym;
    sym = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      sym = SYM_W'(ch - 8'h41);
    end else if (ch inside {[8'h30:8'h39]}) begin
      sym = DIGIT_BASE + SYM_W'(ch - 8'h30);
    end else if (ch == 8'h20) begin
      sym = PAD_SYMBOL;
    end
    return sym;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [SYM_W-1:0] sym);
    logic [CHAR_W-1:0] ch;
    if (sym < DIGIT_BASE) begin
      ch = 8'h41 + CHAR_W'(sym);
    end else if (sym < PAD_SYMBOL) begin
      ch = 8'h30 + CHAR_W'(sym - DIGIT_BASE);
    end else begin
      ch = 8'h20;
    end
    return ch;
  endfunction

  function automatic logic [SYM_W-1:0] key_reduce(input logic [SYM_W-1:0] e);
    return (e >= ALPHA) ? (e - ALPHA) : e;
  endfunction

  function automatic logic [SYM_W-1:0] mod37(input logic [SUM_W-1:0] x);
    logic [SUM_W+14:0] prod;
    logic [SUM_W-1:0]  q;
    logic [SUM_W-1:0]  q37;
    logic [SUM_W-1:0]  r;
    prod = (SUM_W+15)'(x) * (SUM_W+15)'(RECIP);
    q    = SUM_W'(prod >> RECIP_SHIFT);
    q37  = SUM_W'({q, 5'b0}) + SUM_W'({q, 2'b0}) + q;
    r    = x - q37;
    return r[SYM_W-1:0];
  endfunction

endpackage

>>> rtl/core/hill_cipher_mod37_encrypt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encrypt_top: Hill cipher encryptor over 37 symbols
// Collects characters into blocks and emits the key matrix product as text.
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: plain_char [7:0]; tlast: end_of_message
//   out_     master     tdata: cipher_char [7:0]; tlast: last_of_message
//   cfg_     write      index 0 block_size, 1 to 4 key rows zero to three
//
// An input beat is taken whenever the block queue has room.
// Each block gives n output beats, one a cycle while the output is not
// stalled, the first through the sum and output registers after the block
// reaches the head of the queue; the single product row unit sets that pace.
// Reset clears the fill count, the queue and the output stage; block_size
// returns to 4 and the key to zero. A stalled output holds the product unit,
// and the queue then fills and holds the input.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encrypt_top #(
  parameter int MAX_ORDER = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // plain_char [7:0]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // cipher_char [7:0]
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [hcm37_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hcm37_pkg::KEY_ROW_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ORDER + 1);
  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int BLK_W = MAX_ORDER * hcm37_pkg::SYM_W + CNT_W + 1;

  logic [hcm37_pkg::BSIZE_W-1:0] bsize_r;
  logic [hcm37_pkg::BSIZE_W-1:0] bsize_nxt;
  hcm37_pkg::key_rows_t          key_r;
  hcm37_pkg::key_rows_t          key_nxt;

  logic             push_valid;
  logic             push_ready;
  logic [BLK_W-1:0] push_data;
  logic             head_valid;
  logic [BLK_W-1:0] head_data;
  logic             pop;

  always_comb begin
    bsize_nxt = bsize_r;
    key_nxt   = key_r;
    if (cfg_we) begin
      case (hcm37_pkg::cfg_reg_t'(cfg_addr))
        hcm37_pkg::REG_BLOCK_SIZE: begin
          bsize_nxt = cfg_wdata[hcm37_pkg::BSIZE_W-1:0];
        end
        hcm37_pkg::REG_KEY_ROW_ZERO: begin
          key_nxt[0] = cfg_wdata;
        end
        hcm37_pkg::REG_KEY_ROW_ONE: begin
          key_nxt[1] = cfg_wdata;
        end
        hcm37_pkg::REG_KEY_ROW_TWO: begin
          key_nxt[2] = cfg_wdata;
        end
        hcm37_pkg::REG_KEY_ROW_THREE: begin
          key_nxt[3] = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= hcm37_pkg::BSIZE_RESET;
      key_r   <= '0;
    end else begin
      bsize_r <= bsize_nxt;
      key_r   <= key_nxt;
    end
  end

  hcm37_front #(
    .MAX_ORDER (MAX_ORDER),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W),
    .BLK_W     (BLK_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .block_size (bsize_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hcm37_queue #(
    .WIDTH (BLK_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head_data)
  );

  hcm37_back #(
    .MAX_ORDER (MAX_ORDER),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W),
    .BLK_W     (BLK_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_rows   (key_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/hcm37_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm37_front: character intake and block assembly
// Maps each character to its symbol and hands complete or flushed blocks on.
// ----------------------------------------------------------------------------
module hcm37_front #(
  parameter int MAX_ORDER = 4,
  parameter int CNT_W     = $clog2(MAX_ORDER + 1),
  parameter int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  parameter int BLK_W     = MAX_ORDER * hcm37_pkg::SYM_W + CNT_W + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hcm37_pkg::BSIZE_W-1:0]     block_size,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hcm37_pkg::CHAR_W-1:0]      in_tdata,
  input  logic                              in_tlast,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [BLK_W-1:0]                  push_data
);

  logic [CNT_W-1:0]                                 fill_r;
  logic [CNT_W-1:0]                                 fill_nxt;
  logic [MAX_ORDER-1:0][hcm37_pkg::SYM_W-1:0]       sym_r;
  logic [MAX_ORDER-1:0][hcm37_pkg::SYM_W-1:0]       blk_vec;
  logic [hcm37_pkg::SYM_W-1:0]                      new_sym;
  logic [CNT_W-1:0]                                 cnt_new;
  logic [CNT_W-1:0]                                 order_n;
  logic                                             emit;
  logic                                             accept;

  always_comb begin
    if (block_size == '0) begin
      order_n = CNT_W'(1);
    end else if (32'(block_size) > MAX_ORDER) begin
      order_n = CNT_W'(MAX_ORDER);
    end else begin
      order_n = CNT_W'(block_size);
    end
  end

  assign new_sym   = hcm37_pkg::to_symbol(in_tdata);
  assign cnt_new   = fill_r + CNT_W'(1);
  assign emit      = (cnt_new >= order_n) || in_tlast;
  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;
  assign push_valid = in_tvalid && emit;

  always_comb begin
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (32'(cnt_new) > c) begin
        blk_vec[c] = (32'(fill_r) == c) ? new_sym : sym_r[c];
      end else begin
        blk_vec[c] = hcm37_pkg::PAD_SYMBOL;
      end
    end
  end

  assign push_data = {in_tlast, order_n, blk_vec};

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = emit ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r[fill_r[IDX_W-1:0]] <= new_sym;
    end
  end

endmodule

>>> rtl/core/hcm37_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm37_queue: two-entry block queue
// Decouples block assembly from the matrix product so each side stalls alone.
// ----------------------------------------------------------------------------
module hcm37_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [1:0][WIDTH-1:0] entry_r;
  logic                  wptr_r;
  logic                  wptr_nxt;
  logic                  rptr_r;
  logic                  rptr_nxt;
  logic [1:0]            count_r;
  logic [1:0]            count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wptr_nxt  = do_push ? ~wptr_r : wptr_r;
    rptr_nxt  = do_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/hcm37_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm37_back: key matrix product and cipher output
// One key row per cycle while the output is not stalled: products and sum, then modulo 37 into the output beat.
// ----------------------------------------------------------------------------
module hcm37_back #(
  parameter int MAX_ORDER = 4,
  parameter int CNT_W     = $clog2(MAX_ORDER + 1),
  parameter int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  parameter int BLK_W     = MAX_ORDER * hcm37_pkg::SYM_W + CNT_W + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hcm37_pkg::key_rows_t            key_rows,
  input  logic                            head_valid,
  input  logic [BLK_W-1:0]                head_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hcm37_pkg::CHAR_W-1:0]    out_tdata,
  output logic                            out_tlast
);

  localparam int PROD_W = 2 * hcm37_pkg::SYM_W;

  logic [MAX_ORDER-1:0][hcm37_pkg::SYM_W-1:0] vec;
  logic [CNT_W-1:0]                           order_n;
  logic                                       blk_last;
  logic [hcm37_pkg::KEY_ROW_W-1:0]            row_key;
  logic [hcm37_pkg::SUM_W-1:0]                row_sum;
  logic [hcm37_pkg::SYM_W-1:0]                key_e;

  logic [IDX_W-1:0]                row_r;
  logic [IDX_W-1:0]                row_nxt;
  logic                            sum_valid_r;
  logic                            sum_valid_nxt;
  logic [hcm37_pkg::SUM_W-1:0]     sum_r;
  logic                            sum_last_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [hcm37_pkg::CHAR_W-1:0]    out_char_r;
  logic                            out_last_r;

  logic out_free;
  logic sum_move;
  logic sum_free;
  logic issue;
  logic last_row;

  assign {blk_last, order_n, vec} = head_data;

  always_comb begin
    row_key = '0;
    for (int k = 0; k < hcm37_pkg::KEY_REGS; k++) begin
      if (32'(row_r) == k) begin
        row_key = key_rows[k];
      end
    end
  end

  always_comb begin
    row_sum = '0;
    key_e   = '0;
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (c < hcm37_pkg::KEY_REGS && 32'(order_n) > c) begin
        key_e   = hcm37_pkg::key_reduce(row_key[(c % hcm37_pkg::KEY_REGS) *
                                                hcm37_pkg::SYM_W +: hcm37_pkg::SYM_W]);
        row_sum = row_sum + hcm37_pkg::SUM_W'(PROD_W'(key_e) * PROD_W'(vec[c]));
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign sum_move = sum_valid_r && out_free;
  assign sum_free = !sum_valid_r || out_free;
  assign issue    = head_valid && sum_free;
  assign last_row = (CNT_W'(row_r) + CNT_W'(1)) == order_n;
  assign pop      = issue && last_row;

  always_comb begin
    row_nxt       = row_r;
    sum_valid_nxt = sum_valid_r;
    out_valid_nxt = out_valid_r;
    if (issue) begin
      row_nxt = last_row ? '0 : row_r + IDX_W'(1);
    end
    if (issue) begin
      sum_valid_nxt = 1'b1;
    end else if (sum_move) begin
      sum_valid_nxt = 1'b0;
    end
    if (sum_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      sum_valid_r <= sum_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sum_r      <= row_sum;
      sum_last_r <= blk_last && last_row;
    end
    if (sum_move) begin
      out_char_r <= hcm37_pkg::to_ascii(hcm37_pkg::mod37(sum_r));
      out_last_r <= sum_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

>>> tb/sv/hill_cipher_mod37_encrypt_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_mod37_encrypt_top_tb: self-checking bench for the mod-37 Hill encryptor
// Drives plaintext characters under a range of block sizes and keys, predicts
// cipher beats with a behavioural model of the encryptor or takes them from
// directed text, and compares each output beat in order, with random
// back-pressure and idle gaps on both sides.
// ----------------------------------------------------------------------------
module hill_cipher_mod37_encrypt_top_tb;

  localparam int ORDER_MAX   = 4;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_CHARS = 38;
  localparam int NUM_ROWS    = 35;

  typedef struct packed {
    logic [7:0] cipher_char;
    logic       last_of_message;
  } cipher_beat_t;

  typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    hcm37_pkg::cfg_reg_t target;
    logic [23:0]         value;
    logic [7:0]          ch;
    logic                eom;
    logic [31:0]         text;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [hcm37_pkg::CFG_ADDR_W-1:0] cfg_addr = hcm37_pkg::REG_BLOCK_SIZE;
  logic [hcm37_pkg::KEY_ROW_W-1:0]  cfg_wdata = '0;

  // Predictor state.
  logic [2:0]  order_reg;
  logic [23:0] key_row [ORDER_MAX];
  logic [5:0]  held_sym [ORDER_MAX];
  int          held_count;

  cipher_beat_t cipher_expect [$];

  bit idle_on = 1'b1;
  bit hold_out = 1'b0;
  bit cfg_open = 1'b0;
  int cycle_count = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int beats_checked = 0;
  int reg_writes = 0;
  int holds_done = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "A",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "Z",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "0",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "9",   1'b0, "AAAA"},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      " ",   1'b1, "AAAA"},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_ZERO,  24'h000001, 8'h00, 1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_ONE,   24'h000040, 8'h00, 1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_TWO,   24'h001000, 8'h00, 1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_THREE, 24'h040000, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "H",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "I",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      " ",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "9",   1'b1, "HI 9"},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      8'hFF, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "a",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "@",   1'b0, "AAAA"},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "[",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      ":",   1'b1, "AA  "},
    '{ROW_WRITE, hcm37_pkg::REG_BLOCK_SIZE,    24'h000007, 8'h00, 1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_ZERO,  24'hFFFFFF, 8'h00, 1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_THREE, 24'h924924, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "/",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "Z",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "9",   1'b1, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_BLOCK_SIZE,    24'h000000, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "B",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      " ",   1'b1, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_BLOCK_SIZE,    24'h000003, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "Q",   1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "R",   1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_BLOCK_SIZE,    24'h000002, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "S",   1'b0, 32'h0},
    '{ROW_WRITE, hcm37_pkg::REG_KEY_ROW_ONE,   24'h123456, 8'h00, 1'b0, 32'h0},
    '{ROW_CHAR,  hcm37_pkg::REG_BLOCK_SIZE,    24'h0,      "U",   1'b1, 32'h0}
  };

  hill_cipher_mod37_encrypt_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [5:0] char_to_sym(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 6'(ch - "A");
    if (ch >= "0" && ch <= "9") return hcm37_pkg::DIGIT_BASE + 6'(ch - "0");
    if (ch == " ") return hcm37_pkg::PAD_SYMBOL;
    return 6'd0;
  endfunction

  function automatic logic [7:0] sym_to_char(input logic [5:0] sym);
    if (sym < hcm37_pkg::DIGIT_BASE) return "A" + 8'(sym);
    if (sym < hcm37_pkg::PAD_SYMBOL) return "0" + 8'(sym - hcm37_pkg::DIGIT_BASE);
    return " ";
  endfunction

  // Takes one character into the held block and, once the block closes,
  // returns the product of the key matrix and the block as cipher beats.
  function automatic int encrypt_char(input logic [7:0] ch, input logic eom,
                                      output cipher_beat_t [3:0] beats);
    int n;
    int r;
    int c;
    int acc;
    int entry;
    int vec [ORDER_MAX];
    beats = '0;
    n = int'(order_reg);
    if (n == 0) n = 1;
    if (n > ORDER_MAX) n = ORDER_MAX;
    if (held_count < ORDER_MAX) held_sym[held_count] = char_to_sym(ch);
    held_count++;
    if (held_count < n && !eom) return 0;
    for (c = 0; c < n; c++) begin
      vec[c] = (c < held_count) ? int'(held_sym[c]) : int'(hcm37_pkg::PAD_SYMBOL);
    end
    for (r = 0; r < n; r++) begin
      acc = 0;
      for (c = 0; c < n; c++) begin
        entry = int'(key_row[r][6*c +: 6]) % int'(hcm37_pkg::ALPHA);
        acc = (acc + entry * vec[c]) % int'(hcm37_pkg::ALPHA);
      end
      beats[r].cipher_char = sym_to_char(6'(acc));
      beats[r].last_of_message = eom && (r == n - 1);
    end
    held_count = 0;
    return n;
  endfunction

  function automatic logic [23:0] draw_key_row();
    logic [23:0] row;
    int c;
    for (c = 0; c < ORDER_MAX; c++) begin
      case ($urandom_range(0, 5))
        0: row[6*c +: 6] = 6'd0;
        1: row[6*c +: 6] = 6'd36;
        2: row[6*c +: 6] = 6'd37;
        3: row[6*c +: 6] = 6'd63;
        default: row[6*c +: 6] = 6'($urandom_range(0, 63));
      endcase
    end
    return row;
  endfunction

  function automatic logic [7:0] draw_char();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return sym_to_char(6'($urandom_range(0, 36)));
  endfunction

  // Drops valid and lets the block drain and settle before anything else.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (cipher_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input hcm37_pkg::cfg_reg_t target, input logic [23:0] value);
    if (!cfg_open) wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= target;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_open = 1'b1;
    reg_writes++;
    if (target == hcm37_pkg::REG_BLOCK_SIZE) begin
      order_reg = value[2:0];
    end else begin
      key_row[int'(target) - int'(hcm37_pkg::REG_KEY_ROW_ZERO)] = value;
    end
  endtask

  // A non-zero text gives the expected beats directly, first character first.
  task automatic send_char(input logic [7:0] ch, input logic eom, input logic [31:0] text);
    int gap;
    int n;
    int r;
    cipher_beat_t [3:0] beats;
    cipher_beat_t beat;
    if (cfg_open) begin
      cfg_we <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= eom;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    n = encrypt_char(ch, eom, beats);
    for (r = 0; r < n; r++) begin
      if (text != 32'h0) begin
        beat.cipher_char = text[8*(3-r) +: 8];
        beat.last_of_message = eom && (r == n - 1);
      end else begin
        beat = beats[r];
      end
      cipher_expect = {cipher_expect, beat};
    end
  endtask

  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_expect.size() == 0) begin
        $error("unexpected cipher beat: cipher_char %h, last_of_message %b",
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = cipher_expect.pop_front();
        beats_checked++;
        if (out_tdata !== want.cipher_char) begin
          $error("cipher_char: expected %h, got %h", want.cipher_char, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last_of_message) begin
          $error("last_of_message: expected %b, got %b", want.last_of_message, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin : sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        holds_done++;
      end else begin
        stall = idle_on ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int i;
    int phase;
    int msg_left;
    order_reg = hcm37_pkg::BSIZE_RESET;
    for (i = 0; i < ORDER_MAX; i++) begin
      key_row[i] = '0;
      held_sym[i] = '0;
    end
    held_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        cfg_write(directed_rows[i].target, directed_rows[i].value);
      end else begin
        send_char(directed_rows[i].ch, directed_rows[i].eom, directed_rows[i].text);
      end
    end

    // Random phases; a message may run on across a change of settings.
    msg_left = 0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_on = (phase % 4 != 2) && (phase != 1);
      cfg_write(hcm37_pkg::REG_BLOCK_SIZE,
                (phase < 8) ? 24'(phase) : 24'($urandom_range(0, 7)));
      if (phase == 0 || $urandom_range(0, 1) == 1)
        cfg_write(hcm37_pkg::REG_KEY_ROW_ZERO, draw_key_row());
      if (phase == 0 || $urandom_range(0, 1) == 1)
        cfg_write(hcm37_pkg::REG_KEY_ROW_ONE, draw_key_row());
      if (phase == 0 || $urandom_range(0, 1) == 1)
        cfg_write(hcm37_pkg::REG_KEY_ROW_TWO, draw_key_row());
      if (phase == 0 || $urandom_range(0, 1) == 1)
        cfg_write(hcm37_pkg::REG_KEY_ROW_THREE, draw_key_row());
      if (phase == 1) hold_out = 1'b1;
      for (i = 0; i < PHASE_CHARS; i++) begin
        if (phase == 9 && i == PHASE_CHARS / 2) wait_idle();
        if (msg_left == 0) msg_left = $urandom_range(1, 12);
        msg_left--;
        send_char(draw_char(), msg_left == 0, 32'h0);
      end
    end

    wait_idle();
    $display("summary: %0d characters sent, %0d cipher beats checked, %0d register writes",
             chars_sent, beats_checked, reg_writes);
    $display("summary: %0d long output holds, block sizes 0 to 7 and key entries 0 to 63",
             holds_done);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hcm37_pkg.sv
rtl/core/hcm37_front.sv
rtl/core/hcm37_queue.sv
rtl/core/hcm37_back.sv
rtl/core/hill_cipher_mod37_encrypt_top.sv
tb/sv/hill_cipher_mod37_encrypt_top_tb.sv
